// ----- design/adq_pkg.sv -----
// Shared types and codes for the array deque.
`default_nettype none

package adq_pkg;

   localparam int unsigned POS_W  = 6;
   localparam int unsigned DATA_W = 32;

   typedef logic [2:0] req_code_type;
   typedef logic [1:0] status_type;

   localparam req_code_type REQ_PUSH_TAIL = 3'd0;
   localparam req_code_type REQ_PUSH_HEAD = 3'd1;
   localparam req_code_type REQ_POP_TAIL  = 3'd2;
   localparam req_code_type REQ_POP_HEAD  = 3'd3;
   localparam req_code_type REQ_READ_AT   = 3'd4;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_FULL  = 2'd1;
   localparam status_type ST_EMPTY = 2'd2;
   localparam status_type ST_RANGE = 2'd3;

   typedef struct packed {
      logic write;
      logic read;
   } mem_cmd_type;

endpackage

`default_nettype wire

// ----- design/adq_mem.sv -----
// Single-port entry storage with registered read data.
`default_nettype none

module adq_mem #(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned PTR_W = 6
) (
   input  wire logic                          clock,
   input  wire adq_pkg::mem_cmd_type          cmd,
   input  wire logic [PTR_W-1:0]              addr,
   input  wire logic [adq_pkg::DATA_W-1:0]    wdata,
   output logic      [adq_pkg::DATA_W-1:0]    rdata
);

   logic [adq_pkg::DATA_W-1:0] entries [DEPTH];
   logic [adq_pkg::DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         entries[addr] <= wdata;
      end
      if (cmd.read) begin
         rdata_ff <= entries[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- design/adq_ctrl.sv -----
// Head pointer, entry count, request decode and slot addressing.
`default_nettype none

module adq_ctrl #(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned PTR_W = 6,
   parameter int unsigned CNT_W = 7
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire adq_pkg::req_code_type         req_type,
   input  wire logic [adq_pkg::POS_W-1:0]     req_position,
   output adq_pkg::mem_cmd_type               mem_cmd,
   output logic      [PTR_W-1:0]              mem_addr,
   output logic                               rsp_valid,
   output adq_pkg::status_type                rsp_status,
   output logic      [CNT_W-1:0]              rsp_occupancy,
   output logic                               rsp_use_mem
);

   localparam int unsigned BASE_W = (CNT_W > adq_pkg::POS_W) ? CNT_W : adq_pkg::POS_W;
   localparam int unsigned SUM_W  = BASE_W + 1;

   logic [PTR_W-1:0]     head_ff, head_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 valid_ff;
   logic                 use_mem_ff, use_mem_in;
   adq_pkg::status_type  status_ff, status_in;
   adq_pkg::mem_cmd_type cmd;
   logic [PTR_W-1:0]     slot;
   logic [SUM_W-1:0]     head_ext, count_ext, pos_ext;
   logic                 is_full, is_empty;

   function automatic logic [PTR_W-1:0] wrap(input logic [SUM_W-1:0] x);
      logic [SUM_W-1:0] y;
      y = x;
      if (x >= SUM_W'(DEPTH)) begin
         y = x - SUM_W'(DEPTH);
      end
      return y[PTR_W-1:0];
   endfunction

   assign head_ext  = SUM_W'(head_ff);
   assign count_ext = SUM_W'(count_ff);
   assign pos_ext   = SUM_W'(req_position);
   assign is_full   = (count_ext >= SUM_W'(DEPTH));
   assign is_empty  = (count_ff == '0);

   always_comb begin
      head_in    = head_ff;
      count_in   = count_ff;
      status_in  = adq_pkg::ST_OK;
      use_mem_in = 1'b0;
      cmd        = '0;
      slot       = head_ff;
      unique case (req_type)
         adq_pkg::REQ_PUSH_TAIL: begin
            slot = wrap(head_ext + count_ext);
            if (is_full) begin
               status_in = adq_pkg::ST_FULL;
            end else begin
               cmd.write = 1'b1;
               count_in  = count_ff + CNT_W'(1);
            end
         end
         adq_pkg::REQ_PUSH_HEAD: begin
            slot = (head_ff == '0) ? PTR_W'(DEPTH - 1) : head_ff - PTR_W'(1);
            if (is_full) begin
               status_in = adq_pkg::ST_FULL;
            end else begin
               cmd.write = 1'b1;
               head_in   = slot;
               count_in  = count_ff + CNT_W'(1);
            end
         end
         adq_pkg::REQ_POP_TAIL: begin
            slot = wrap(head_ext + count_ext - SUM_W'(1));
            if (is_empty) begin
               status_in = adq_pkg::ST_EMPTY;
            end else begin
               cmd.read   = 1'b1;
               use_mem_in = 1'b1;
               count_in   = count_ff - CNT_W'(1);
            end
         end
         adq_pkg::REQ_POP_HEAD: begin
            slot = head_ff;
            if (is_empty) begin
               status_in = adq_pkg::ST_EMPTY;
            end else begin
               cmd.read   = 1'b1;
               use_mem_in = 1'b1;
               head_in    = wrap(head_ext + SUM_W'(1));
               count_in   = count_ff - CNT_W'(1);
            end
         end
         adq_pkg::REQ_READ_AT: begin
            slot = wrap(head_ext + pos_ext);
            if (is_empty) begin
               status_in = adq_pkg::ST_EMPTY;
            end else if (pos_ext >= count_ext) begin
               status_in = adq_pkg::ST_RANGE;
            end else begin
               cmd.read   = 1'b1;
               use_mem_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         count_ff   <= '0;
         valid_ff   <= 1'b0;
         use_mem_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
         if (accept) begin
            head_ff    <= head_in;
            count_ff   <= count_in;
            use_mem_ff <= use_mem_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
      end
   end

   assign mem_cmd.write  = accept & cmd.write;
   assign mem_cmd.read   = accept & cmd.read;
   assign mem_addr       = slot;
   assign rsp_valid      = valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_occupancy  = count_ff;
   assign rsp_use_mem    = use_mem_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count exceeds depth");

   a_reject_holds: assert property (@(posedge clock) disable iff (reset)
      accept && status_in != adq_pkg::ST_OK |=> $stable(count_ff) && $stable(head_ff))
      else $error("rejected request changed state");

   a_one_access: assert property (@(posedge clock) disable iff (reset)
      !(mem_cmd.write && mem_cmd.read))
      else $error("read and write issued together");

   a_mem_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_use_mem |-> rsp_status == adq_pkg::ST_OK)
      else $error("data returned on rejected request");

endmodule

`default_nettype wire

// ----- design/array_deque_top.sv -----
// Top level of the bounded double-ended queue over a circular entry memory.
//
//  channel   ports                                         transfer when
//  request   start, busy, req_type, req_value, req_position start && !busy
//  response  rsp_valid, rsp_read_data, rsp_status,          rsp_valid
//            rsp_occupancy
//
// One request per cycle while busy is low; its response appears in the cycle after the transfer,
// through the entry memory's registered read port.
// Each request makes at most one memory access, so there is no stall between requests.
// busy is high only while reset is asserted; reset clears head pointer and count.
// The receiver cannot stall: each response is valid for exactly one cycle.
`default_nettype none

module array_deque_top #(
   parameter int unsigned DEPTH = 64,
   localparam int unsigned PTR_W = $clog2(DEPTH),
   localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic        [2:0]                  req_type,
   input  wire logic signed [adq_pkg::DATA_W-1:0]  req_value,
   input  wire logic        [adq_pkg::POS_W-1:0]   req_position,
   output logic                                    rsp_valid,
   output logic signed      [adq_pkg::DATA_W-1:0]  rsp_read_data,
   output logic             [1:0]                  rsp_status,
   output logic             [CNT_W-1:0]            rsp_occupancy
);

   logic                       accept;
   adq_pkg::mem_cmd_type       mem_cmd;
   logic [PTR_W-1:0]           mem_addr;
   logic [adq_pkg::DATA_W-1:0] mem_rdata;
   logic                       use_mem;
   adq_pkg::status_type        status;

   assign busy   = reset;
   assign accept = start & ~busy;

   adq_ctrl #(
      .DEPTH (DEPTH),
      .PTR_W (PTR_W),
      .CNT_W (CNT_W)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .req_type      (req_type),
      .req_position  (req_position),
      .mem_cmd       (mem_cmd),
      .mem_addr      (mem_addr),
      .rsp_valid     (rsp_valid),
      .rsp_status    (status),
      .rsp_occupancy (rsp_occupancy),
      .rsp_use_mem   (use_mem)
   );

   adq_mem #(
      .DEPTH (DEPTH),
      .PTR_W (PTR_W)
   ) u_mem (
      .clock (clock),
      .cmd   (mem_cmd),
      .addr  (mem_addr),
      .wdata (req_value),
      .rdata (mem_rdata)
   );

   assign rsp_read_data = use_mem ? $signed(mem_rdata) : '0;
   assign rsp_status    = status;

endmodule

`default_nettype wire
